@@ design/mmn_pkg.sv @@
// Shared types and constants for the min-max normalizer.
// No dependencies; imported by every module of the block except mmn_ram.
package mmn_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LOWER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPPER = 1'b1;

  localparam sample_t MIN_RESET   = 16'sh7FFF;
  localparam sample_t MAX_RESET   = 16'sh8000;
  localparam sample_t LOWER_RESET = 16'sh0000;
  localparam sample_t UPPER_RESET = 16'sh0100;

  // One finished data set, handed from the front to the back
  typedef struct packed {
    logic    bank;
    sample_t min_val;
    sample_t max_val;
    logic    overflow;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_MUL,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ design/mmn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/mmn_front.sv @@
// Load side: accepts samples, writes them to the current bank, tracks min/max.
// Depends on mmn_pkg; hands a job_t to the job queue on the last sample.
module mmn_front
  import mmn_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int ADDR_W       = $clog2(MAX_ELEMENTS),
  parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  sample_t           sample,
  input  logic              last_element,
  output logic              ram_we,
  output logic [ADDR_W:0]   ram_waddr,
  output sample_t           ram_wdata,
  output logic              job_push,
  output job_t              job,
  output logic [CNT_W-1:0]  job_count
);

  sample_t          min_r, min_nxt;
  sample_t          max_r, max_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ov_r, ov_nxt;
  logic             bank_r, bank_nxt;
  logic             can_store;

  assign can_store = count_r < CNT_W'(MAX_ELEMENTS);
  assign ram_waddr = {bank_r, count_r[ADDR_W-1:0]};
  assign ram_wdata = sample;

  // Store or drop the request, close the set on the last element
  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    count_nxt = count_r;
    ov_nxt    = ov_r;
    bank_nxt  = bank_r;
    ram_we    = 1'b0;
    if (accept) begin
      if (can_store) begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        if (sample < min_r) min_nxt = sample;
        if (sample > max_r) max_nxt = sample;
      end else begin
        ov_nxt = 1'b1;
      end
    end
    job_push     = accept & last_element;
    job.bank     = bank_r;
    job.min_val  = min_nxt;
    job.max_val  = max_nxt;
    job.overflow = ov_nxt;
    job_count    = count_nxt;
    if (job_push) begin
      min_nxt   = MIN_RESET;
      max_nxt   = MAX_RESET;
      count_nxt = '0;
      ov_nxt    = 1'b0;
      bank_nxt  = ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= MIN_RESET;
      max_r   <= MAX_RESET;
      count_r <= '0;
      ov_r    <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

@@ design/mmn_back.sv @@
// Emit side: reads a finished bank, rescales each sample with a bit-serial
// divider and holds the result in an output register. Depends on mmn_pkg.
module mmn_back
  import mmn_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int ADDR_W       = $clog2(MAX_ELEMENTS),
  parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sample_t           lower_bound,
  input  sample_t           upper_bound,
  input  logic              job_valid,
  input  job_t              job,
  input  logic [CNT_W-1:0]  job_count,
  output logic              job_done,
  output logic              ram_re,
  output logic [ADDR_W:0]   ram_raddr,
  input  sample_t           ram_rdata,
  output logic              out_empty,
  input  logic              out_pop,
  output sample_t           out_scaled,
  output logic              out_final_result,
  output logic              out_dropped
);

  back_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [15:0]          span_r, span_nxt;
  logic                 flat_r, flat_nxt;
  logic [15:0]          rmag_r, rmag_nxt;
  logic                 rneg_r, rneg_nxt;
  logic [15:0]          diff_r, diff_nxt;
  logic [31:0]          work_r, work_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sample_t              out_scaled_r, out_scaled_nxt;
  logic                 out_final_r, out_final_nxt;
  logic                 out_dropped_r, out_dropped_nxt;

  logic signed [16:0] range_s;
  logic [16:0]        span_w;
  logic [16:0]        diff_w;
  logic [32:0]        shifted;
  logic [16:0]        trial;
  logic [15:0]        quot;
  sample_t            result;
  logic               is_final;
  logic               out_load;

  assign range_s  = 17'(upper_bound) - 17'(lower_bound);
  assign span_w   = 17'(job.max_val) - 17'(job.min_val);
  assign diff_w   = 17'(ram_rdata) - 17'(job.min_val);
  assign shifted  = {work_r, 1'b0};
  assign trial    = shifted[32:16];
  assign quot     = work_r[15:0];
  assign result   = flat_r ? lower_bound
                  : (rneg_r ? lower_bound - sample_t'(quot) : lower_bound + sample_t'(quot));
  assign is_final = (idx_r + 1'b1) == job_count;
  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_pop);

  assign ram_raddr = {job.bank, idx_r[ADDR_W-1:0]};

  // Sequencer: read, subtract, multiply, divide, deliver
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    step_nxt        = step_r;
    span_nxt        = span_r;
    flat_nxt        = flat_r;
    rmag_nxt        = rmag_r;
    rneg_nxt        = rneg_r;
    diff_nxt        = diff_r;
    work_nxt        = work_r;
    ram_re          = 1'b0;
    job_done        = 1'b0;
    out_valid_nxt   = out_valid_r;
    out_scaled_nxt  = out_scaled_r;
    out_final_nxt   = out_final_r;
    out_dropped_nxt = out_dropped_r;

    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          idx_nxt   = '0;
          span_nxt  = span_w[15:0];
          flat_nxt  = job.max_val == job.min_val;
          rneg_nxt  = range_s[16];
          rmag_nxt  = range_s[16] ? 16'(-range_s) : range_s[15:0];
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        ram_re    = 1'b1;
        state_nxt = B_LOAD;
      end
      B_LOAD: begin
        diff_nxt  = diff_w[15:0];
        state_nxt = B_MUL;
      end
      B_MUL: begin
        // Quotient fits 16 bits since the sample never exceeds the maximum
        work_nxt  = diff_r * rmag_r;
        step_nxt  = '0;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        // One restoring division step per cycle
        if (trial >= {1'b0, span_r}) begin
          work_nxt = {16'(trial - {1'b0, span_r}), shifted[15:1], 1'b1};
        end else begin
          work_nxt = shifted[31:0];
        end
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_load) begin
          out_valid_nxt   = 1'b1;
          out_scaled_nxt  = result;
          out_final_nxt   = is_final;
          out_dropped_nxt = job.overflow;
          if (is_final) begin
            job_done  = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = B_READ;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    step_r        <= step_nxt;
    span_r        <= span_nxt;
    flat_r        <= flat_nxt;
    rmag_r        <= rmag_nxt;
    rneg_r        <= rneg_nxt;
    diff_r        <= diff_nxt;
    work_r        <= work_nxt;
    out_scaled_r  <= out_scaled_nxt;
    out_final_r   <= out_final_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_empty        = ~out_valid_r;
  assign out_scaled       = out_scaled_r;
  assign out_final_result = out_final_r;
  assign out_dropped      = out_dropped_r;

endmodule

@@ design/min_max_normalizer_unit.sv @@
// Min-max normalizer top level: loading accepts one sample per cycle while in_full is low;
// each emitted result goes through RAM read, subtract, multiply and a 16-step divider.
// Two RAM banks and a two-entry job queue let a new set load while one emits.
// Reset (synchronous, rst_n low) clears min/max/count, the queue and bounds
// to lower 0, upper 1.0; the sample RAM is not cleared.
module min_max_normalizer_unit
  import mmn_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  sample_t               in_sample,
  input  logic                  in_last_element,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sample_t               out_scaled,
  output logic                  out_final_result,
  output logic                  out_dropped,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SAMPLE_W-1:0]   cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int DEPTH  = 2 * (1 << ADDR_W);

  sample_t lower_r, upper_r;

  logic              accept;
  logic              ram_we, ram_re;
  logic [ADDR_W:0]   ram_waddr, ram_raddr;
  sample_t           ram_wdata, ram_rdata;
  logic              job_push, job_done;
  job_t              push_job;
  logic [CNT_W-1:0]  push_count;

  job_t              q_job_r [2];
  logic [CNT_W-1:0]  q_cnt_r [2];
  logic              q_wr_r, q_rd_r;
  logic [1:0]        q_fill_r;

  // Bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOWER: lower_r <= cfg_wdata;
        CFG_UPPER: upper_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Both banks busy when two jobs wait
  assign in_full = q_fill_r[1];
  assign accept  = in_push & ~in_full;

  mmn_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sample       (in_sample),
    .last_element (in_last_element),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .job_push     (job_push),
    .job          (push_job),
    .job_count    (push_count)
  );

  mmn_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Job queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r   <= 1'b0;
      q_rd_r   <= 1'b0;
      q_fill_r <= '0;
    end else begin
      if (job_push) q_wr_r <= ~q_wr_r;
      if (job_done) q_rd_r <= ~q_rd_r;
      q_fill_r <= q_fill_r + {1'b0, job_push} - {1'b0, job_done};
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      q_job_r[q_wr_r] <= push_job;
      q_cnt_r[q_wr_r] <= push_count;
    end
  end

  mmn_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .lower_bound      (lower_r),
    .upper_bound      (upper_r),
    .job_valid        (q_fill_r != 2'd0),
    .job              (q_job_r[q_rd_r]),
    .job_count        (q_cnt_r[q_rd_r]),
    .job_done         (job_done),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_scaled       (out_scaled),
    .out_final_result (out_final_result),
    .out_dropped      (out_dropped)
  );

endmodule

@@ tb/mmn_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard for the min-max normalizer: watches the load, result and register ports,
// predicts every normalized sample and compares each popped result field by field.
// Depends on mmn_pkg for sample_t and the register indexes.
module mmn_scoreboard
  import mmn_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  sample_t               in_sample,
  input  logic                  in_last_element,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  sample_t               out_scaled,
  input  logic                  out_final_result,
  input  logic                  out_dropped,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SAMPLE_W-1:0]   cfg_wdata,
  output int                    pending_results,
  output int                    error_count
);

  typedef struct packed {
    sample_t scaled;
    logic    final_result;
    logic    dropped;
  } norm_result_t;

  // Expected normalized samples, oldest first
  norm_result_t normalized_q[$];

  // Shadow of the set being loaded and of the bound registers
  sample_t held_samples[MAX_ELEMENTS];
  sample_t set_min;
  sample_t set_max;
  int      held_count;
  logic    set_overflow;
  sample_t lower_q;
  sample_t upper_q;

  // lower + (x - min) * (upper - lower) / (max - min), truncated toward zero
  function automatic sample_t rescale_sample(sample_t x);
    longint span;
    longint num;
    span = longint'(set_max) - longint'(set_min);
    if (span <= 0) return lower_q;
    num = (longint'(x) - longint'(set_min)) * (longint'(upper_q) - longint'(lower_q));
    return sample_t'(longint'(lower_q) + num / span);
  endfunction

  initial begin
    pending_results = 0;
    error_count     = 0;
  end

  always @(posedge clk) begin : watch
    norm_result_t want;
    norm_result_t got;
    norm_result_t expected_item;
    if (!rst_n) begin
      set_min      = MIN_RESET;
      set_max      = MAX_RESET;
      held_count   = 0;
      set_overflow = 1'b0;
      lower_q      = LOWER_RESET;
      upper_q      = UPPER_RESET;
      normalized_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LOWER: lower_q = cfg_wdata;
          CFG_UPPER: upper_q = cfg_wdata;
          default: ;
        endcase
      end

      // popped result against the oldest expectation
      if (!out_empty && out_pop) begin
        got = '{out_scaled, out_final_result, out_dropped};
        if (normalized_q.size() == 0) begin
          $display("%0t: result with nothing expected: scaled=%0d final=%b dropped=%b",
                   $time, got.scaled, got.final_result, got.dropped);
          error_count++;
        end else begin
          want = normalized_q.pop_front();
          if (got.scaled !== want.scaled) begin
            $display("%0t: scaled mismatch: expected %0d actual %0d",
                     $time, want.scaled, got.scaled);
            error_count++;
          end
          if (got.final_result !== want.final_result) begin
            $display("%0t: final_result mismatch: expected %b actual %b",
                     $time, want.final_result, got.final_result);
            error_count++;
          end
          if (got.dropped !== want.dropped) begin
            $display("%0t: dropped mismatch: expected %b actual %b",
                     $time, want.dropped, got.dropped);
            error_count++;
          end
        end
      end

      // accepted sample: store or drop, then emit the set on last
      if (in_push && !in_full) begin
        if (held_count < MAX_ELEMENTS) begin
          held_samples[held_count] = in_sample;
          held_count++;
          if (in_sample < set_min) set_min = in_sample;
          if (in_sample > set_max) set_max = in_sample;
        end else begin
          set_overflow = 1'b1;
        end
        if (in_last_element) begin
          for (int k = 0; k < held_count; k++) begin
            expected_item.scaled       = rescale_sample(held_samples[k]);
            expected_item.final_result = (k == held_count - 1);
            expected_item.dropped      = set_overflow;
            normalized_q = {normalized_q, expected_item};
          end
          set_min      = MIN_RESET;
          set_max      = MAX_RESET;
          held_count   = 0;
          set_overflow = 1'b0;
        end
      end
    end
    pending_results = normalized_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the min-max normalizer testbench: clock, reset, sample, pop and register stimulus.
// Depends on mmn_pkg, min_max_normalizer_unit and mmn_scoreboard.
module testbench;
  import mmn_pkg::*;

  localparam int MAX_ELEMENTS = 64;
  localparam int RANDOM_ITEMS = 170;
  localparam int PHASE_ITEMS = 15;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  sample_t               in_sample;
  logic                  in_last_element;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  sample_t               out_scaled;
  logic                  out_final_result;
  logic                  out_dropped;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [SAMPLE_W-1:0]   cfg_wdata;
  int                    pending_results;
  int                    error_count;

  int burst_left = 0;
  int sent_items = 0;
  int pop_mode = 0;
  int pop_stretch = 0;

  always #2 clk = ~clk;

  min_max_normalizer_unit #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample        (in_sample),
    .in_last_element  (in_last_element),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_scaled       (out_scaled),
    .out_final_result (out_final_result),
    .out_dropped      (out_dropped),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  mmn_scoreboard #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample        (in_sample),
    .in_last_element  (in_last_element),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_scaled       (out_scaled),
    .out_final_result (out_final_result),
    .out_dropped      (out_dropped),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .pending_results  (pending_results),
    .error_count      (error_count)
  );

  // Result side: stretches of always-pop, coin-flip pop and long stalls
  always @(negedge clk) begin
    if (pop_stretch == 0) begin
      pop_mode    = $urandom_range(0, 2);
      pop_stretch = $urandom_range(5, 60);
    end
    pop_stretch--;
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom_range(0, 1));
      default: out_pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_push <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // One load request; bursts of random length with random gaps between them
  task automatic push_sample(sample_t value, logic last);
    if (burst_left == 0) begin
      idle_input(($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5));
      burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_push         <= 1'b1;
    in_sample       <= value;
    in_last_element <= last;
    do @(posedge clk); while (in_full);
    sent_items++;
  endtask

  // Hold off loading until every expected result has been popped
  task automatic drain_and_settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] index, sample_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_bounds(sample_t lo, sample_t hi);
    drain_and_settle();
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, hi);
  endtask

  // styles: full range, narrow cluster, flat, extremes only
  function automatic sample_t pick_sample(int style, sample_t base);
    case (style)
      0: return sample_t'($urandom);
      1: return base + sample_t'($urandom_range(0, 15));
      2: return base;
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(int size, int style);
    sample_t base;
    base = sample_t'($urandom);
    for (int i = 0; i < size; i++) push_sample(pick_sample(style, base), i == size - 1);
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    sample_t lo;
    sample_t hi;
    int      random_goal;
    int      phase_goal;
    int      set_no;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_sample       = '0;
    in_last_element = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_LOWER;
    cfg_wdata       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset bounds: field extremes, then a flat set and a one-sample set
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'sh0001, 1'b0);
    push_sample(16'shFFFF, 1'b1);
    push_sample(16'sh1234, 1'b0);
    push_sample(16'sh1234, 1'b0);
    push_sample(16'sh1234, 1'b1);
    push_sample(16'sh7FFF, 1'b1);

    // widest target range over the widest input span
    set_bounds(16'sh8000, 16'sh7FFF);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh3039, 1'b0);
    push_sample(16'sh7FFF, 1'b1);

    // inverted bounds give a descending map
    set_bounds(16'sh7FFF, 16'sh8000);
    push_sample(16'sh0064, 1'b0);
    push_sample(16'shFF9C, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'sh0032, 1'b1);

    // random phases, each with its own bounds
    random_goal = sent_items + RANDOM_ITEMS;
    set_no      = 0;
    for (int phase = 0; sent_items < random_goal; phase++) begin
      case (phase % 5)
        0: begin
          lo = sample_t'($urandom);
          hi = sample_t'($urandom);
        end
        1: begin
          lo = 16'sh8000;
          hi = 16'sh7FFF;
        end
        2: begin
          lo = sample_t'($urandom_range(0, 32767));
          hi = -sample_t'($urandom_range(0, 32767));
        end
        3: begin
          lo = sample_t'($urandom);
          hi = lo;
        end
        default: begin
          lo = LOWER_RESET;
          hi = UPPER_RESET;
        end
      endcase
      set_bounds(lo, hi);
      phase_goal = sent_items + PHASE_ITEMS;
      while (sent_items < phase_goal) begin
        // a full set without drops, and one whose last three samples are dropped
        if (set_no == 0) send_set(MAX_ELEMENTS, 0);
        else if (set_no == 1) send_set(MAX_ELEMENTS + 3, 1);
        else if ($urandom_range(0, 11) == 0) send_set($urandom_range(60, 70), $urandom_range(0, 3));
        else send_set($urandom_range(1, 8), $urandom_range(0, 3));
        set_no++;
      end
    end

    drain_and_settle();
    if (error_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
